>>> design/bpm_clock_generator_unit_assert.svh
// Assertion macros for the tempo clock generator unit.
`ifndef BPM_CLOCK_GENERATOR_UNIT_ASSERT_SVH
`define BPM_CLOCK_GENERATOR_UNIT_ASSERT_SVH
`ifndef SYNTHESIS
// Implication check, sampled on the rising clock, off during reset.
`define BCG_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("bpm clock generator: check failed");
// Condition in one cycle implies a condition in the next cycle.
`define BCG_ASSERT_NEXT(lbl, clk, rstn, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("bpm clock generator: next-cycle check failed");
`else
`define BCG_ASSERT(lbl, clk, rstn, prop)
`define BCG_ASSERT_NEXT(lbl, clk, rstn, pre, post)
`endif
`endif

>>> design/bcg_pkg.sv
// Types and constants of the tempo clock generator.
package bcg_pkg;

  // Default accumulator width
  localparam int unsigned PHASE_BITS_DEF = 32;

  // Configuration register indexes
  localparam logic [2:0] CFG_CLOCK_MULTIPLIER = 3'd0;
  localparam logic [2:0] CFG_GATE_LENGTH      = 3'd1;
  localparam logic [2:0] CFG_RESET_LENGTH     = 3'd2;
  localparam logic [2:0] CFG_SAMPLE_RATE      = 3'd3;
  localparam logic [2:0] CFG_FADER_RANGE      = 3'd4;

  // Configuration reset values
  localparam logic [4:0]  CM_RST = 5'd4;
  localparam logic [20:0] GL_RST = 21'd240;
  localparam logic [20:0] RL_RST = 21'd480;
  localparam logic [17:0] SR_RST = 18'd48000;
  localparam logic [5:0]  FR_RST = 6'd1;

  // Input clamps
  localparam logic [3:0]        DIGIT_MAX = 4'd10;
  localparam logic [7:0]        FINE_MAX  = 8'd128;
  localparam logic signed [17:0] FINE_ZERO = 18'sd64;
  localparam logic signed [10:0] FADER_MAX = 11'sd512;
  localparam logic signed [10:0] FADER_MIN = -11'sd512;
  localparam logic [5:0]        RANGE_MIN = 6'd1;
  localparam logic [5:0]        RANGE_MAX = 6'd50;

  // Digit weights in centi-BPM
  localparam logic [17:0] W_HUNDREDS = 18'd10000;
  localparam logic [17:0] W_TENS     = 18'd1000;
  localparam logic [17:0] W_ONES     = 18'd100;

  // Wrap threshold scale: 60 s times 100 centi-BPM
  localparam logic signed [29:0] WRAP_SCALE = 30'sd6000;

  // Fader term divide: floor((x + 25600) / 51200), taken as (x >> 11) / 25.
  // The divide by 25 multiplies by ceil(2^24 / 25) and keeps bits 24 and up,
  // exact for every dividend below 2^24 / 9, which the clamped inputs keep to.
  localparam int unsigned        QUO_BITS    = 16;
  localparam int unsigned        DIV_SHIFT   = 11;
  localparam int unsigned        DIV_Y_BITS  = 21;
  localparam int unsigned        RECIP_SHIFT = 24;
  localparam logic signed [23:0] RECIP_25    = 24'sd671089;
  localparam logic signed [33:0] ROUND_BIAS  = 34'sd25600;
  localparam logic [33:0]        CEIL_BIAS   = 34'd51199;

  // Sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_THR,
    ST_MUL_FADER,
    ST_MUL_RANGE,
    ST_DIV_PREP,
    ST_DIVIDE,
    ST_TEMPO,
    ST_MUL_TEMPO,
    ST_PHASE,
    ST_WRAP
  } state_e;

endpackage

>>> design/bpm_clock_generator_unit.sv
// Tempo clock generator: phase accumulator clocked once per audio sample tick.
// After the transfer, each tick steps through the sequencer states in order;
// a stalled result holds it in the wrap state until the output frees, and
// no new tick is taken until then. The sequencer runs one shared 30x24
// signed multiplier (wrap threshold, fader product, range scale, reciprocal
// divide of the rounded fader term by 51200, tempo times multiplier), one
// step each. The input stalls for the whole tick. Configuration writes are
// always ready and are written at once, so a write during a tick can affect it.
module bpm_clock_generator_unit #(
  parameter int unsigned PHASE_BITS = bcg_pkg::PHASE_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // input channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               run_on_i,
  input  logic               reset_level_i,
  input  logic [3:0]         bpm_hundreds_i,
  input  logic [3:0]         bpm_tens_i,
  input  logic [3:0]         bpm_ones_i,
  input  logic [7:0]         bpm_fine_i,
  input  logic signed [10:0] fader_amount_i,
  // output channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               clock_gate_o,
  output logic               reset_gate_o,
  output logic signed [18:0] tempo_centi_o,
  // configuration write channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [20:0]        cfg_data_i
);

`include "bpm_clock_generator_unit_assert.svh"

  localparam int unsigned CW = ((PHASE_BITS > 31) ? PHASE_BITS : 31) + 1;
  localparam logic signed [PHASE_BITS-1:0] PMAX = {1'b0, {(PHASE_BITS-1){1'b1}}};
  localparam logic signed [PHASE_BITS-1:0] PMIN = {1'b1, {(PHASE_BITS-1){1'b0}}};

  bcg_pkg::state_e state_q, state_d;

  // configuration
  logic [4:0]  cm_q;
  logic [20:0] gl_q, rl_q;
  logic [17:0] sr_q;
  logic [5:0]  rng_cfg_q;
  logic [5:0]  rng;

  // captured tick
  logic               run_q, rlev_q;
  logic signed [17:0] base_q;
  logic signed [10:0] fr_q;

  // working registers
  logic [30:0]                     thr_q;
  logic signed [28:0]              p1_q;
  logic signed [33:0]              prod_q;
  logic [bcg_pkg::DIV_Y_BITS-1:0]  div_y_q;
  logic [bcg_pkg::QUO_BITS-1:0]    quo_q;
  logic                            neg_q;
  logic signed [18:0]              tempo_q;
  logic signed [23:0]              tm_q;
  logic                            edge_q;

  // state of the clock
  logic signed [PHASE_BITS-1:0] phase_q;
  logic                         prev_run_q, prev_reset_q;
  logic [20:0]                  gate_left_q, reset_left_q;

  // output register
  logic               out_valid_q, out_valid_d;
  logic               clock_gate_q, reset_gate_q;
  logic signed [18:0] tempo_out_q;

  // sequencer outputs
  logic               accept;
  logic               commit;
  logic signed [29:0] mul_a;
  logic signed [23:0] mul_b;
  logic signed [53:0] mul_p;

  // input clamping and digit sum
  logic [3:0]         h_c, t_c, o_c;
  logic [7:0]         f_c;
  logic [17:0]        digit_sum;
  logic signed [17:0] base_d;
  logic signed [10:0] fr_d;

  always_comb begin
    h_c = (bpm_hundreds_i > bcg_pkg::DIGIT_MAX) ? bcg_pkg::DIGIT_MAX : bpm_hundreds_i;
    t_c = (bpm_tens_i > bcg_pkg::DIGIT_MAX) ? bcg_pkg::DIGIT_MAX : bpm_tens_i;
    o_c = (bpm_ones_i > bcg_pkg::DIGIT_MAX) ? bcg_pkg::DIGIT_MAX : bpm_ones_i;
    f_c = (bpm_fine_i > bcg_pkg::FINE_MAX) ? bcg_pkg::FINE_MAX : bpm_fine_i;
    digit_sum = 18'(h_c) * bcg_pkg::W_HUNDREDS + 18'(t_c) * bcg_pkg::W_TENS
              + 18'(o_c) * bcg_pkg::W_ONES + 18'(f_c);
    base_d = signed'(digit_sum) - bcg_pkg::FINE_ZERO;
    if (fader_amount_i > bcg_pkg::FADER_MAX) begin
      fr_d = bcg_pkg::FADER_MAX;
    end else if (fader_amount_i < bcg_pkg::FADER_MIN) begin
      fr_d = bcg_pkg::FADER_MIN;
    end else begin
      fr_d = fader_amount_i;
    end
  end

  // fader range clamp
  always_comb begin
    if (rng_cfg_q < bcg_pkg::RANGE_MIN) begin
      rng = bcg_pkg::RANGE_MIN;
    end else if (rng_cfg_q > bcg_pkg::RANGE_MAX) begin
      rng = bcg_pkg::RANGE_MAX;
    end else begin
      rng = rng_cfg_q;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      bcg_pkg::ST_IDLE:      if (in_valid_i) state_d = bcg_pkg::ST_MUL_THR;
      bcg_pkg::ST_MUL_THR:   state_d = bcg_pkg::ST_MUL_FADER;
      bcg_pkg::ST_MUL_FADER: state_d = bcg_pkg::ST_MUL_RANGE;
      bcg_pkg::ST_MUL_RANGE: state_d = bcg_pkg::ST_DIV_PREP;
      bcg_pkg::ST_DIV_PREP:  state_d = bcg_pkg::ST_DIVIDE;
      bcg_pkg::ST_DIVIDE:    state_d = bcg_pkg::ST_TEMPO;
      bcg_pkg::ST_TEMPO:     state_d = bcg_pkg::ST_MUL_TEMPO;
      bcg_pkg::ST_MUL_TEMPO: state_d = bcg_pkg::ST_PHASE;
      bcg_pkg::ST_PHASE:     state_d = bcg_pkg::ST_WRAP;
      bcg_pkg::ST_WRAP:      if (!out_valid_q || !out_stall_i) state_d = bcg_pkg::ST_IDLE;
      default:               state_d = bcg_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs: handshake and shared multiplier operands
  always_comb begin
    in_stall_o = (state_q != bcg_pkg::ST_IDLE);
    accept     = in_valid_i && (state_q == bcg_pkg::ST_IDLE);
    commit     = (state_q == bcg_pkg::ST_WRAP) && (!out_valid_q || !out_stall_i);
    mul_a      = '0;
    mul_b      = '0;
    case (state_q)
      bcg_pkg::ST_MUL_THR: begin
        mul_a = bcg_pkg::WRAP_SCALE;
        mul_b = signed'({6'b0, sr_q});
      end
      bcg_pkg::ST_MUL_FADER: begin
        mul_a = signed'({{12{base_q[17]}}, base_q});
        mul_b = signed'({{13{fr_q[10]}}, fr_q});
      end
      bcg_pkg::ST_MUL_RANGE: begin
        mul_a = signed'({p1_q[28], p1_q});
        mul_b = signed'({18'b0, rng});
      end
      bcg_pkg::ST_DIVIDE: begin
        mul_a = signed'({9'b0, div_y_q});
        mul_b = bcg_pkg::RECIP_25;
      end
      bcg_pkg::ST_MUL_TEMPO: begin
        mul_a = signed'({{11{tempo_q[18]}}, tempo_q});
        mul_b = signed'({19'b0, cm_q});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // shared multiplier
  assign mul_p = mul_a * mul_b;

  // divider setup: magnitude for a floor division of a signed numerator
  logic signed [33:0] num_d;
  logic [33:0]        neg_num;
  logic [33:0]        mag_d;
  assign num_d   = prod_q + bcg_pkg::ROUND_BIAS;
  assign neg_num = 34'd0 - unsigned'(num_d);
  assign mag_d   = num_d[33] ? (neg_num + bcg_pkg::CEIL_BIAS) : unsigned'(num_d);

  // signed quotient added to the base tempo
  logic signed [18:0] quo_ext;
  logic signed [18:0] tempo_d;
  assign quo_ext = signed'({3'b000, quo_q});
  assign tempo_d = signed'({base_q[17], base_q}) + (neg_q ? -quo_ext : quo_ext);

  // phase advance with saturation
  logic                         edge_d;
  logic signed [PHASE_BITS-1:0] ph0;
  logic signed [PHASE_BITS:0]   psum;
  logic signed [PHASE_BITS-1:0] psat;
  logic signed [PHASE_BITS-1:0] phase_adv_d;
  always_comb begin
    edge_d = (run_q && !prev_run_q) || (rlev_q && !prev_reset_q);
    ph0    = edge_d ? '0 : phase_q;
    psum   = signed'({ph0[PHASE_BITS-1], ph0})
           + signed'({{(PHASE_BITS+1-24){tm_q[23]}}, tm_q});
    if (psum[PHASE_BITS] != psum[PHASE_BITS-1]) begin
      psat = psum[PHASE_BITS] ? PMIN : PMAX;
    end else begin
      psat = psum[PHASE_BITS-1:0];
    end
    phase_adv_d = run_q ? psat : ph0;
  end

  // wrap compare and subtract
  logic signed [CW-1:0] phase_ext, thr_ext, phase_sub;
  logic                 wrap_d;
  always_comb begin
    phase_ext = signed'({{(CW-PHASE_BITS){phase_q[PHASE_BITS-1]}}, phase_q});
    thr_ext   = signed'({{(CW-31){1'b0}}, thr_q});
    phase_sub = phase_ext - thr_ext;
    wrap_d    = run_q && (phase_ext >= thr_ext);
  end

  // pulse counters
  logic        fire;
  logic [20:0] rl1, gl1;
  logic        clk_gate_d, rst_gate_d;
  always_comb begin
    fire       = edge_q || wrap_d;
    rl1        = (edge_q && (rl_q > reset_left_q)) ? rl_q : reset_left_q;
    gl1        = (fire && (gl_q > gate_left_q)) ? gl_q : gate_left_q;
    rst_gate_d = (rl1 != '0);
    clk_gate_d = run_q && (gl1 != '0);
  end

  assign out_valid_d = commit || (out_valid_q && out_stall_i);

  // control and clock state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= bcg_pkg::ST_IDLE;
      phase_q      <= '0;
      prev_run_q   <= 1'b0;
      prev_reset_q <= 1'b0;
      gate_left_q  <= '0;
      reset_left_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      if (state_q == bcg_pkg::ST_PHASE) begin
        phase_q <= phase_adv_d;
      end
      if (commit) begin
        if (wrap_d) phase_q <= phase_sub[PHASE_BITS-1:0];
        prev_run_q   <= run_q;
        prev_reset_q <= rlev_q;
        reset_left_q <= rl1 - 21'(rst_gate_d);
        gate_left_q  <= gl1 - 21'(clk_gate_d);
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cm_q      <= bcg_pkg::CM_RST;
      gl_q      <= bcg_pkg::GL_RST;
      rl_q      <= bcg_pkg::RL_RST;
      sr_q      <= bcg_pkg::SR_RST;
      rng_cfg_q <= bcg_pkg::FR_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        bcg_pkg::CFG_CLOCK_MULTIPLIER: cm_q      <= cfg_data_i[4:0];
        bcg_pkg::CFG_GATE_LENGTH:      gl_q      <= cfg_data_i;
        bcg_pkg::CFG_RESET_LENGTH:     rl_q      <= cfg_data_i;
        bcg_pkg::CFG_SAMPLE_RATE:      sr_q      <= cfg_data_i[17:0];
        bcg_pkg::CFG_FADER_RANGE:      rng_cfg_q <= cfg_data_i[5:0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      run_q  <= run_on_i;
      rlev_q <= reset_level_i;
      base_q <= base_d;
      fr_q   <= fr_d;
    end
    case (state_q)
      bcg_pkg::ST_MUL_THR:   thr_q  <= unsigned'(mul_p[30:0]);
      bcg_pkg::ST_MUL_FADER: p1_q   <= mul_p[28:0];
      bcg_pkg::ST_MUL_RANGE: prod_q <= mul_p[33:0];
      bcg_pkg::ST_DIV_PREP: begin
        neg_q   <= num_d[33];
        div_y_q <= mag_d[bcg_pkg::DIV_SHIFT +: bcg_pkg::DIV_Y_BITS];
      end
      // reciprocal multiply gives the divide by 25
      bcg_pkg::ST_DIVIDE:    quo_q   <= mul_p[bcg_pkg::RECIP_SHIFT +: bcg_pkg::QUO_BITS];
      bcg_pkg::ST_TEMPO:     tempo_q <= tempo_d;
      bcg_pkg::ST_MUL_TEMPO: tm_q    <= mul_p[23:0];
      bcg_pkg::ST_PHASE:     edge_q  <= edge_d;
      default: ;
    endcase
    if (commit) begin
      clock_gate_q <= clk_gate_d;
      reset_gate_q <= rst_gate_d;
      tempo_out_q  <= tempo_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign clock_gate_o  = clock_gate_q;
  assign reset_gate_o  = reset_gate_q;
  assign tempo_centi_o = tempo_out_q;

  // checks
  `BCG_ASSERT_NEXT(a_accept_starts, clk_i, rst_ni, accept, state_q == bcg_pkg::ST_MUL_THR)
  `BCG_ASSERT_NEXT(a_result_from_wrap, clk_i, rst_ni, (state_q != bcg_pkg::ST_WRAP) && !out_valid_q, !out_valid_q)
  `BCG_ASSERT(a_quotient_fits, clk_i, rst_ni, (state_q == bcg_pkg::ST_DIVIDE) |-> (mul_p[53:40] == '0))
  `BCG_ASSERT_NEXT(a_divide_one_step, clk_i, rst_ni, state_q == bcg_pkg::ST_DIVIDE, state_q == bcg_pkg::ST_TEMPO)

endmodule
